/* rtl/sle_pkg.sv */
// Shared types and constants for the sequential list engine.
// No dependencies; imported by the engine, both checkers and the bench.
`timescale 1ns / 1ps

package sle_pkg;

   // storage depth, the address width derived from it, and the other widths
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 9;
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STAT_W   = 2;

   // request operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR   = 3'd0,
      MODE_INSERT  = 3'd1,
      MODE_DELETE  = 3'd2,
      MODE_REVERSE = 3'd3,
      MODE_READ    = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

/* rtl/sequential_list_engine.sv */
// Ordered list of signed words with insert, delete, reverse, read and clear.
// Clear, rejected requests and reverse of under two words answer straight from the decode state;
// read passes through a read state; insert shifts the tail up and then writes the value, delete
// shifts the tail down, reverse swaps word pairs; one memory read and one write a cycle.
// One request at a time: busy is high from accept until the strobe; the receiver cannot stall.
// Reset (synchronous, active high) empties the list; element storage is not cleared.
`timescale 1ns / 1ps

module sequential_list_engine
   import sle_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [LEN_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]         rsp_list_length
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_READ   = 9'b000000100,
      S_SHIFT  = 9'b000001000,
      S_PUT    = 9'b000010000,
      S_RV_LO  = 9'b000100000,
      S_RV_HI  = 9'b001000000,
      S_RV_WLO = 9'b010000000,
      S_RV_WHI = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  cur_ff, cur_in;
   logic [LEN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pdst_ff, pdst_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;
   logic [DATA_W-1:0] hold_ff, hold_in;
   logic [DATA_W-1:0] rdata_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;

   // element storage
   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic              accept;
   logic              is_insert;
   logic              respond;
   status_type        fin_status;
   logic [DATA_W-1:0] fin_value;

   assign accept    = start && (state_ff == S_IDLE);
   assign is_insert = (mode_ff == MODE_INSERT);

   // sequencer: one memory read and one memory write per cycle
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      rd_cnt_in  = rd_cnt_ff;
      pend_in    = 1'b0;
      pdst_in    = pdst_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      hold_in    = hold_ff;
      mem_we     = 1'b0;
      mem_waddr  = pdst_ff;
      mem_wdata  = rdata_ff;
      mem_raddr  = pos_ff[ADDR_W-1:0];
      respond    = 1'b0;
      fin_status = ST_DONE;
      fin_value  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               pos_in   = req_position;
               val_in   = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // decide the operation; read address is already the position
            case (mode_ff)
               MODE_CLEAR: begin
                  count_in = '0;
                  respond  = 1'b1;
               end
               MODE_INSERT: begin
                  if (pos_ff > count_ff) begin
                     fin_status = ST_RANGE;
                     respond    = 1'b1;
                  end else if (count_ff >= LEN_W'(CAPACITY)) begin
                     fin_status = ST_FULL;
                     respond    = 1'b1;
                  end else begin
                     rd_cnt_in = count_ff - pos_ff;
                     cur_in    = count_ff - LEN_W'(1);
                     state_in  = S_SHIFT;
                  end
               end
               MODE_DELETE: begin
                  if (pos_ff >= count_ff) begin
                     fin_status = ST_RANGE;
                     respond    = 1'b1;
                  end else begin
                     rd_cnt_in = count_ff - pos_ff - LEN_W'(1);
                     cur_in    = pos_ff + LEN_W'(1);
                     state_in  = S_SHIFT;
                  end
               end
               MODE_REVERSE: begin
                  if (count_ff < LEN_W'(2)) begin
                     respond = 1'b1;
                  end else begin
                     lo_in    = '0;
                     hi_in    = ADDR_W'(count_ff - LEN_W'(1));
                     state_in = S_RV_LO;
                  end
               end
               MODE_READ: begin
                  if (pos_ff >= count_ff) begin
                     fin_status = ST_RANGE;
                     respond    = 1'b1;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  fin_status = ST_RANGE;
                  respond    = 1'b1;
               end
            endcase
         end
         S_READ: begin
            fin_value = rdata_ff;
            respond   = 1'b1;
         end
         S_SHIFT: begin
            // write back the word read in the previous cycle
            mem_we    = pend_ff;
            mem_waddr = pdst_ff;
            mem_wdata = rdata_ff;
            if (rd_cnt_ff != '0) begin
               mem_raddr = cur_ff[ADDR_W-1:0];
               pend_in   = 1'b1;
               rd_cnt_in = rd_cnt_ff - LEN_W'(1);
               if (is_insert) begin
                  pdst_in = cur_ff[ADDR_W-1:0] + ADDR_W'(1);
                  cur_in  = cur_ff - LEN_W'(1);
               end else begin
                  pdst_in = cur_ff[ADDR_W-1:0] - ADDR_W'(1);
                  cur_in  = cur_ff + LEN_W'(1);
               end
            end else if (!pend_ff) begin
               if (is_insert) begin
                  state_in = S_PUT;
               end else begin
                  count_in = count_ff - LEN_W'(1);
                  respond  = 1'b1;
               end
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + LEN_W'(1);
            respond   = 1'b1;
         end
         S_RV_LO: begin
            mem_raddr = lo_ff;
            state_in  = S_RV_HI;
         end
         S_RV_HI: begin
            mem_raddr = hi_ff;
            hold_in   = rdata_ff;
            state_in  = S_RV_WLO;
         end
         S_RV_WLO: begin
            // low slot takes the high word; fetch the next low word
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = rdata_ff;
            mem_raddr = lo_ff + ADDR_W'(1);
            state_in  = S_RV_WHI;
         end
         S_RV_WHI: begin
            // high slot takes the held low word; fetch the next high word
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = hold_ff;
            mem_raddr = hi_ff - ADDR_W'(1);
            hold_in   = rdata_ff;
            lo_in     = lo_ff + ADDR_W'(1);
            hi_in     = hi_ff - ADDR_W'(1);
            if ((lo_ff + ADDR_W'(1)) < (hi_ff - ADDR_W'(1))) begin
               state_in = S_RV_WLO;
            end else begin
               respond = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (respond) begin
         state_in = S_IDLE;
      end
   end

   // result strobe
   always_comb begin
      rsp_valid_in  = respond;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      if (respond) begin
         rsp_status_in = fin_status;
         rsp_value_in  = fin_value;
         rsp_length_in = count_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      rd_cnt_ff     <= rd_cnt_in;
      pdst_ff       <= pdst_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem_ff[mem_raddr];
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_list_length = rsp_length_ff;

endmodule

/* rtl/sle_checker.sv */
// Port-level checker for the sequential list engine, bound into the engine module.
// Depends on sle_pkg for widths, status codes and the capacity.
`timescale 1ns / 1ps

module sle_checker
   import sle_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [STAT_W-1:0]        rsp_status,
   input logic signed [DATA_W-1:0] rsp_read_value,
   input logic [LEN_W-1:0]         rsp_list_length
);

   // an accepted request makes the engine busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a request");

   // the engine frees itself when it shows a result
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // one strobe per request
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a failed request reads nothing
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_read_value == '0))
      else $error("non-zero read value on a failed request");

   // length stays within capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_length <= LEN_W'(CAPACITY)))
      else $error("list length beyond capacity");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_read_value  (rsp_read_value),
   .rsp_list_length (rsp_list_length)
);

/* bench/sle_port_checker.sv */
// Port checker for the sequential list engine: tracks the list, predicts each result.
// Depends on sle_pkg; sits beside the engine and only watches its ports.
`timescale 1ns / 1ps

module sle_port_checker
   import sle_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [LEN_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic signed [DATA_W-1:0] rsp_read_value,
   input  logic [LEN_W-1:0]         rsp_list_length,
   output int                       fail_count,
   output int                       awaited_count,
   output int                       results_checked,
   output int                       full_refusals,
   output logic [LEN_W-1:0]         tracked_length
);

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         list_length;
   } list_result_type;

   // shadow copy of the element store and its length
   logic signed [DATA_W-1:0] shadow_words [CAPACITY];
   int                       words_held;
   list_result_type          awaited_results [$];
   list_result_type          due;

   assign tracked_length = LEN_W'(words_held);

   initial begin
      fail_count      = 0;
      awaited_count   = 0;
      results_checked = 0;
      full_refusals   = 0;
      words_held      = 0;
      foreach (shadow_words[i]) shadow_words[i] = '0;
   end

   // Apply one request to the shadow list and return the result it should give
   function automatic list_result_type apply_list_request(input logic [MODE_W-1:0] mode,
                                                          input logic [LEN_W-1:0] pos,
                                                          input logic signed [DATA_W-1:0] val);
      list_result_type          res;
      logic signed [DATA_W-1:0] swap;
      int                       i;
      res.status     = ST_DONE;
      res.read_value = '0;
      case (mode)
         MODE_CLEAR: begin
            words_held = 0;
         end
         MODE_INSERT: begin
            // position check takes precedence over the full check
            if (pos > words_held) begin
               res.status = ST_RANGE;
            end else if (words_held >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = words_held; i > pos; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = val;
               words_held++;
            end
         end
         MODE_DELETE: begin
            if (pos >= words_held) begin
               res.status = ST_RANGE;
            end else begin
               for (i = pos; i + 1 < words_held; i++) shadow_words[i] = shadow_words[i+1];
               words_held--;
            end
         end
         MODE_REVERSE: begin
            for (i = 0; i < words_held / 2; i++) begin
               swap                           = shadow_words[i];
               shadow_words[i]                = shadow_words[words_held-1-i];
               shadow_words[words_held-1-i]   = swap;
            end
         end
         MODE_READ: begin
            if (pos >= words_held) res.status = ST_RANGE;
            else res.read_value = shadow_words[pos];
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.list_length = LEN_W'(words_held);
      return res;
   endfunction

   // Check the result strobe first, then queue the prediction for a new request
   always @(posedge clock) begin
      if (reset) begin
         words_held = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $error("result strobe with no request outstanding: status %0d length %0d",
                      rsp_status, rsp_list_length);
               fail_count++;
            end else begin
               due = awaited_results.pop_front();
               results_checked++;
               if (due.status == ST_FULL) full_refusals++;
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  fail_count++;
               end
               if (rsp_read_value !== due.read_value) begin
                  $error("read_value: expected %0d, got %0d", due.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_list_length !== due.list_length) begin
                  $error("list_length: expected %0d, got %0d",
                         due.list_length, rsp_list_length);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            awaited_results.push_back(apply_list_request(req_mode, req_position, req_value));
      end
      awaited_count = awaited_results.size();
   end

endmodule

/* bench/tb_sequential_list_engine.sv */
// Top-level bench for the sequential list engine: clock, reset, request stimulus, verdict.
// Depends on sle_pkg, sequential_list_engine and sle_port_checker.
`timescale 1ns / 1ps

module tb_sequential_list_engine;
   import sle_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 12;
   localparam int TARGET_REQUESTS = 1300;
   localparam int FILL_SPACING    = 450;
   localparam int POS_MAX         = (1 << LEN_W) - 1;
   localparam int MODE_MAX        = (1 << MODE_W) - 1;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [MODE_W-1:0]        req_mode;
   logic [LEN_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]         rsp_list_length;

   int               fail_count;
   int               awaited_count;
   int               results_checked;
   int               full_refusals;
   logic [LEN_W-1:0] tracked_length;

   int issued;
   int fills;
   int stall_cycles;
   int mode_tally [MODE_MAX+1];
   bit no_idle;

   sequential_list_engine uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_list_length (rsp_list_length)
   );

   sle_port_checker port_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_list_length (rsp_list_length),
      .fail_count      (fail_count),
      .awaited_count   (awaited_count),
      .results_checked (results_checked),
      .full_refusals   (full_refusals),
      .tracked_length  (tracked_length)
   );

   always #4 clock = ~clock;

   // Abort when neither a request nor a result moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Present one request at a falling edge and hold it until the engine takes it
   task automatic issue(input logic [MODE_W-1:0] mode, input int pos,
                        input logic [DATA_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode     <= mode;
      req_position <= LEN_W'(pos);
      req_value    <= val;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      issued++;
      mode_tally[mode]++;
   endtask

   // One random request, shaped by the current length; inserts give way to
   // deletes once the list reaches the ceiling
   task automatic random_request(input int len_ceiling);
      int len;
      int r;
      int pos;
      len = tracked_length;
      r   = $urandom_range(0, 99);
      if (r < 38 && len < len_ceiling) begin
         pos = ($urandom_range(0, 19) == 0) ? $urandom_range(len + 1, POS_MAX)
                                            : $urandom_range(0, len);
         issue(MODE_INSERT, pos, pick_value());
      end else if (r < 62) begin
         pos = (len == 0 || $urandom_range(0, 11) == 0) ? $urandom_range(len, POS_MAX)
                                                        : $urandom_range(0, len - 1);
         issue(MODE_DELETE, pos, pick_value());
      end else if (r < 85) begin
         pos = (len == 0 || $urandom_range(0, 11) == 0) ? $urandom_range(len, POS_MAX)
                                                        : $urandom_range(0, len - 1);
         issue(MODE_READ, pos, pick_value());
      end else if (r < 93) begin
         issue(MODE_REVERSE, $urandom_range(0, POS_MAX), pick_value());
      end else if (r < 96) begin
         issue(MODE_CLEAR, $urandom_range(0, POS_MAX), pick_value());
      end else begin
         issue(MODE_W'($urandom_range(int'(MODE_READ) + 1, MODE_MAX)),
               $urandom_range(0, POS_MAX), pick_value());
      end
   endtask

   // Grow the list to capacity, work the edges of a full list, then empty it
   task automatic fill_to_capacity();
      int len;
      int back;
      issue(MODE_CLEAR, $urandom_range(0, POS_MAX), pick_value());
      len = tracked_length;
      while (len < CAPACITY) begin
         back = $urandom_range(0, (len < 3) ? len : 3);
         issue(MODE_INSERT, len - back, pick_value());
         len = tracked_length;
      end
      issue(MODE_INSERT, 0, pick_value());
      issue(MODE_INSERT, CAPACITY, pick_value());
      issue(MODE_INSERT, CAPACITY + 1, pick_value());
      issue(MODE_INSERT, POS_MAX, pick_value());
      issue(MODE_READ, CAPACITY - 1, pick_value());
      issue(MODE_READ, CAPACITY, pick_value());
      issue(MODE_REVERSE, $urandom_range(0, POS_MAX), pick_value());
      issue(MODE_READ, 0, pick_value());
      issue(MODE_READ, CAPACITY - 1, pick_value());
      issue(MODE_DELETE, CAPACITY - 1, pick_value());
      issue(MODE_INSERT, CAPACITY - 1, pick_value());
      issue(MODE_DELETE, 0, pick_value());
      issue(MODE_INSERT, 0, pick_value());
      repeat (6) issue(MODE_READ, $urandom_range(0, CAPACITY - 1), pick_value());
      issue(MODE_CLEAR, $urandom_range(0, POS_MAX), pick_value());
      fills++;
   endtask

   initial begin
      int ceiling;
      int run_len;
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = '0;
      req_position = '0;
      req_value    = '0;
      issued       = 0;
      fills        = 0;
      stall_cycles = 0;
      no_idle      = 1'b0;
      foreach (mode_tally[m]) mode_tally[m] = 0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // empty list: every position is out of range, reverse is harmless
      issue(MODE_READ, 0, '0);
      issue(MODE_DELETE, 0, '0);
      issue(MODE_INSERT, 1, '1);
      issue(MODE_REVERSE, 0, '0);
      // build a short list from the value extremes, front, back and middle
      issue(MODE_INSERT, 0, {1'b0, {(DATA_W-1){1'b1}}});
      issue(MODE_INSERT, 0, {1'b1, {(DATA_W-1){1'b0}}});
      issue(MODE_INSERT, 2, '1);
      issue(MODE_INSERT, 1, '0);
      issue(MODE_READ, 0, '0);
      issue(MODE_READ, 3, '0);
      issue(MODE_READ, 4, '0);
      issue(MODE_REVERSE, POS_MAX, '1);
      issue(MODE_READ, 0, '0);
      issue(MODE_READ, 1, '0);
      // delete last, first, then past the end
      issue(MODE_DELETE, 3, '0);
      issue(MODE_DELETE, 0, '0);
      issue(MODE_DELETE, 2, '0);
      issue(MODE_READ, POS_MAX, '0);
      issue(MODE_INSERT, POS_MAX, 32'hA5A5_5A5A);
      issue(MODE_INSERT, CAPACITY, 32'h5A5A_A5A5);
      // unused modes change nothing
      for (int m = int'(MODE_READ) + 1; m <= MODE_MAX; m++)
         issue(MODE_W'(m), POS_MAX, '1);
      issue(MODE_CLEAR, POS_MAX, '1);
      issue(MODE_READ, 0, '0);

      // random runs of requests, with two trips to a full list on the way
      while (issued < TARGET_REQUESTS) begin
         if (fills < 2 && issued >= (fills + 1) * FILL_SPACING) begin
            fill_to_capacity();
         end else begin
            no_idle = ($urandom_range(0, 3) == 0);
            ceiling = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 120)
                                                  : $urandom_range(2, 24);
            run_len = $urandom_range(15, 50);
            repeat (run_len) random_request(ceiling);
         end
      end
      start <= 1'b0;

      // drain outstanding results, then leave room for any stray strobe
      while (awaited_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d requests: %0d insert, %0d delete, %0d read, %0d reverse, %0d clear, %0d unused mode",
               issued, mode_tally[MODE_INSERT], mode_tally[MODE_DELETE],
               mode_tally[MODE_READ], mode_tally[MODE_REVERSE], mode_tally[MODE_CLEAR],
               issued - mode_tally[MODE_INSERT] - mode_tally[MODE_DELETE]
                      - mode_tally[MODE_READ] - mode_tally[MODE_REVERSE]
                      - mode_tally[MODE_CLEAR]);
      $display("%0d results checked, %0d inserts refused on a full list, %0d fills to capacity",
               results_checked, full_refusals, fills);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
